// ===== src/pve_pkg.sv =====
// Package: shared types, marker constants and descriptor layout for the PackStream value encoder.
`timescale 1ns / 1ps

package pve_pkg;

    // Item kinds on the action field
    typedef enum logic [3:0] {
        ActNull   = 4'd0,
        ActBool   = 4'd1,
        ActInt    = 4'd2,
        ActFloat  = 4'd3,
        ActStr    = 4'd4,
        ActList   = 4'd5,
        ActMap    = 4'd6,
        ActStruct = 4'd7,
        ActData   = 4'd8
    } t_action;

    // Header families sharing the tiny/8/16/32 size forms
    typedef enum logic [1:0] {
        HdrStr  = 2'd0,
        HdrList = 2'd1,
        HdrMap  = 2'd2
    } t_hdr_kind;

    typedef enum logic [1:0] {
        FormTiny = 2'd0,
        Form8    = 2'd1,
        Form16   = 2'd2,
        Form32   = 2'd3
    } t_hdr_form;

    // Marker bytes
    localparam logic [7:0] MkNull     = 8'hC0;
    localparam logic [7:0] MkFloat64  = 8'hC1;
    localparam logic [7:0] MkFalse    = 8'hC2;
    localparam logic [7:0] MkTrue     = 8'hC3;
    localparam logic [7:0] MkInt8     = 8'hC8;
    localparam logic [7:0] MkInt16    = 8'hC9;
    localparam logic [7:0] MkInt32    = 8'hCA;
    localparam logic [7:0] MkInt64    = 8'hCB;
    localparam logic [7:0] MkStruct8  = 8'hDC;
    localparam logic [7:0] MkStruct16 = 8'hDD;
    localparam logic [7:0] MkTStruct  = 8'hB0;

    // Range limits
    localparam logic signed [63:0] TinyIntMin = -64'sd16;
    localparam logic signed [63:0] TinyIntMax = 64'sd127;
    localparam logic [31:0]        TinySizeMax  = 32'h0000_000F;
    localparam logic [31:0]        Size8Max     = 32'h0000_00FF;
    localparam logic [31:0]        Size16Max    = 32'h0000_FFFF;

    // Payload bytes of one item at most, and queue sizing
    localparam int PayloadBytes = 8;
    localparam int FifoDepth    = 4;
    localparam int FifoAw       = $clog2(FifoDepth);

    // One classified item: marker, left-aligned big-endian payload, payload length
    typedef struct packed {
        logic        status_err;
        logic [7:0]  marker;
        logic [63:0] payload;
        logic [3:0]  nbytes;
    } t_desc;

    // Marker for a string, list or map header in a given size form
    function automatic logic [7:0] hdr_mark(input t_hdr_kind kind, input t_hdr_form form);
        logic [7:0] m;
        m = 8'h00;
        unique case (kind)
            HdrStr: begin
                unique case (form)
                    FormTiny: m = 8'h80;
                    Form8:    m = 8'hD0;
                    Form16:   m = 8'hD1;
                    default:  m = 8'hD2;
                endcase
            end
            HdrList: begin
                unique case (form)
                    FormTiny: m = 8'h90;
                    Form8:    m = 8'hD4;
                    Form16:   m = 8'hD5;
                    default:  m = 8'hD6;
                endcase
            end
            default: begin
                unique case (form)
                    FormTiny: m = 8'hA0;
                    Form8:    m = 8'hD8;
                    Form16:   m = 8'hD9;
                    default:  m = 8'hDA;
                endcase
            end
        endcase
        return m;
    endfunction

endpackage

// ===== src/packstream_value_encoder.sv =====
// Top level: PackStream v1 value encoder, classifier, descriptor queue and serializer.
`timescale 1ns / 1ps
//
// Usage:
//   Input side is a queue: drive an item on i_action/i_value/i_count/i_tag/
//   i_data_byte with i_push; the transaction completes on an edge where
//   o_full is low. Action codes 9..15 are taken and dropped silently.
//   Result side is a queue: while o_empty is low the oldest encoded byte
//   sits on o_out_byte with o_byte_valid, o_last_of_item and o_status;
//   i_pop takes it. Bytes come marker first, then payload big-endian.
//   The marker of an item passes through the descriptor queue, then the output register,
//   to reach the result ports. Throughput: one result per cycle on the output side while
//   i_pop takes each result, so an item occupies the serializer for its marker plus up
//   to eight payload bytes, which sets the rate; a four-entry descriptor queue lets
//   the front keep taking items while long ones are being sent.
//   A struct header with count above 0xFFFF latches an error: it and every
//   later item yield one status-only result (o_status high, no byte).
//   Reset (synchronous, active low) empties the queue and clears the error.
//   When the receiver stalls, the output register holds and the queue fills,
//   then o_full rises.

module packstream_value_encoder
    import pve_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [3:0]         i_action,
    input  logic signed [63:0] i_value,
    input  logic [31:0]        i_count,
    input  logic [7:0]         i_tag,
    input  logic [7:0]         i_data_byte,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [7:0]         o_out_byte,
    output logic               o_byte_valid,
    output logic               o_last_of_item,
    output logic               o_status
);

    logic  w_accept;
    logic  w_push;
    t_desc w_desc_in;
    t_desc w_desc_out;
    logic  w_err;
    logic  w_q_full;
    logic  w_q_empty;
    logic  w_q_pop;

    assign o_full   = w_q_full;
    assign w_accept = i_push && !w_q_full;

    pve_classify u_classify (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_action    (i_action),
        .i_value     (i_value),
        .i_count     (i_count),
        .i_tag       (i_tag),
        .i_data_byte (i_data_byte),
        .o_push      (w_push),
        .o_desc      (w_desc_in),
        .o_err       (w_err)
    );

    pve_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_desc_in),
        .i_pop   (w_q_pop),
        .o_data  (w_desc_out),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    pve_serialize u_serialize (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_desc         (w_desc_out),
        .i_desc_empty   (w_q_empty),
        .o_desc_pop     (w_q_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_out_byte     (o_out_byte),
        .o_byte_valid   (o_byte_valid),
        .o_last_of_item (o_last_of_item),
        .o_status       (o_status)
    );

    // Oversized struct header latches the error on the next edge
    a_err_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && i_action == ActStruct && i_count > Size16Max) |=> w_err)
        else $error("struct overflow did not latch error");

    // Error is sticky until reset
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_err |=> w_err)
        else $error("error flag cleared without reset");

    // A status result carries no byte and closes its item
    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_status) |-> (!o_byte_valid && o_last_of_item))
        else $error("status result malformed");

    // Queue never reports full and empty together
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_full && w_q_empty))
        else $error("descriptor queue full and empty at once");

endmodule

// ===== src/pve_classify.sv =====
// Front end: accepts value items, picks the encoding form and holds the sticky error.
`timescale 1ns / 1ps

module pve_classify
    import pve_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [3:0]         i_action,
    input  logic signed [63:0] i_value,
    input  logic [31:0]        i_count,
    input  logic [7:0]         i_tag,
    input  logic [7:0]         i_data_byte,
    output logic               o_push,
    output t_desc              o_desc,
    output logic               o_err
);

    logic       r_err;
    logic       n_err;
    logic       w_known;
    logic       w_struct_big;
    t_hdr_kind  w_kind;
    t_desc      w_norm;

    assign w_known      = (i_action <= ActData);
    assign w_struct_big = (i_action == ActStruct) && (i_count > Size16Max);

    // Header family for string, list and map
    always_comb begin
        unique case (i_action)
            ActStr:  w_kind = HdrStr;
            ActList: w_kind = HdrList;
            default: w_kind = HdrMap;
        endcase
    end

    // Encoding form of a normal item
    always_comb begin
        w_norm            = '0;
        w_norm.status_err = 1'b0;
        unique case (i_action)
            ActNull: w_norm.marker = MkNull;
            ActBool: w_norm.marker = i_value[0] ? MkTrue : MkFalse;
            ActInt: begin
                priority if (i_value >= TinyIntMin && i_value <= TinyIntMax) begin
                    w_norm.marker = i_value[7:0];
                end else if (i_value == {{56{i_value[7]}}, i_value[7:0]}) begin
                    w_norm.marker  = MkInt8;
                    w_norm.payload = {i_value[7:0], 56'd0};
                    w_norm.nbytes  = 4'd1;
                end else if (i_value == {{48{i_value[15]}}, i_value[15:0]}) begin
                    w_norm.marker  = MkInt16;
                    w_norm.payload = {i_value[15:0], 48'd0};
                    w_norm.nbytes  = 4'd2;
                end else if (i_value == {{32{i_value[31]}}, i_value[31:0]}) begin
                    w_norm.marker  = MkInt32;
                    w_norm.payload = {i_value[31:0], 32'd0};
                    w_norm.nbytes  = 4'd4;
                end else begin
                    w_norm.marker  = MkInt64;
                    w_norm.payload = i_value;
                    w_norm.nbytes  = 4'(PayloadBytes);
                end
            end
            ActFloat: begin
                w_norm.marker  = MkFloat64;
                w_norm.payload = i_value;
                w_norm.nbytes  = 4'(PayloadBytes);
            end
            ActStr, ActList, ActMap: begin
                priority if (i_count <= TinySizeMax) begin
                    w_norm.marker = hdr_mark(w_kind, FormTiny) | {4'd0, i_count[3:0]};
                end else if (i_count <= Size8Max) begin
                    w_norm.marker  = hdr_mark(w_kind, Form8);
                    w_norm.payload = {i_count[7:0], 56'd0};
                    w_norm.nbytes  = 4'd1;
                end else if (i_count <= Size16Max) begin
                    w_norm.marker  = hdr_mark(w_kind, Form16);
                    w_norm.payload = {i_count[15:0], 48'd0};
                    w_norm.nbytes  = 4'd2;
                end else begin
                    w_norm.marker  = hdr_mark(w_kind, Form32);
                    w_norm.payload = {i_count, 32'd0};
                    w_norm.nbytes  = 4'd4;
                end
            end
            ActStruct: begin
                // tag byte rides as the last payload byte
                priority if (i_count <= TinySizeMax) begin
                    w_norm.marker  = MkTStruct | {4'd0, i_count[3:0]};
                    w_norm.payload = {i_tag, 56'd0};
                    w_norm.nbytes  = 4'd1;
                end else if (i_count <= Size8Max) begin
                    w_norm.marker  = MkStruct8;
                    w_norm.payload = {i_count[7:0], i_tag, 48'd0};
                    w_norm.nbytes  = 4'd2;
                end else begin
                    w_norm.marker  = MkStruct16;
                    w_norm.payload = {i_count[15:0], i_tag, 40'd0};
                    w_norm.nbytes  = 4'd3;
                end
            end
            default: w_norm.marker = i_data_byte;
        endcase
    end

    // Error path overrides: one status-only result per item
    always_comb begin
        n_err  = r_err;
        o_desc = w_norm;
        if (r_err || w_struct_big) begin
            o_desc            = '0;
            o_desc.status_err = 1'b1;
        end
        if (i_accept && w_known && w_struct_big) begin
            n_err = 1'b1;
        end
    end

    assign o_push = i_accept && w_known;
    assign o_err  = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else begin
            r_err <= n_err;
        end
    end

endmodule

// ===== src/pve_fifo.sv =====
// Descriptor queue between the classifier and the byte serializer.
`timescale 1ns / 1ps

module pve_fifo
    import pve_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_data,
    input  logic  i_pop,
    output t_desc o_data,
    output logic  o_full,
    output logic  o_empty
);

    t_desc             r_mem [FifoDepth];
    logic [FifoAw-1:0] r_wr_ptr;
    logic [FifoAw-1:0] r_rd_ptr;
    logic [FifoAw:0]   r_cnt;
    logic              w_wr;
    logic              w_rd;

    assign o_full  = (r_cnt == (FifoAw+1)'(FifoDepth));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== src/pve_serialize.sv =====
// Back end: walks one descriptor out as bytes into the output register.
`timescale 1ns / 1ps

module pve_serialize
    import pve_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_desc      i_desc,
    input  logic       i_desc_empty,
    output logic       o_desc_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_last_of_item,
    output logic       o_status
);

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_byte_valid;
    logic        r_last;
    logic        r_status;
    logic        r_act;
    logic [63:0] r_shift;
    logic [3:0]  r_left;
    logic        w_slot;

    // Output slot frees when empty or its transaction completes this edge
    assign w_slot     = !r_out_valid || i_pop;
    assign o_desc_pop = w_slot && !r_act && !i_desc_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_act       <= 1'b0;
        end else if (w_slot) begin
            priority if (r_act) begin
                // next payload byte, big-endian
                r_out_valid  <= 1'b1;
                r_out_byte   <= r_shift[63:56];
                r_byte_valid <= 1'b1;
                r_status     <= 1'b0;
                r_last       <= (r_left == 4'd1);
                r_shift      <= {r_shift[55:0], 8'd0};
                r_left       <= r_left - 4'd1;
                if (r_left == 4'd1) begin
                    r_act <= 1'b0;
                end
            end else if (!i_desc_empty) begin
                // marker byte or status-only result
                r_out_valid  <= 1'b1;
                r_out_byte   <= i_desc.status_err ? 8'd0 : i_desc.marker;
                r_byte_valid <= !i_desc.status_err;
                r_status     <= i_desc.status_err;
                r_last       <= i_desc.status_err || (i_desc.nbytes == 4'd0);
                r_shift      <= i_desc.payload;
                r_left       <= i_desc.nbytes;
                r_act        <= !i_desc.status_err && (i_desc.nbytes != 4'd0);
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_byte_valid   = r_byte_valid;
    assign o_last_of_item = r_last;
    assign o_status       = r_status;

endmodule
